// ===== hdl/tdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer deadline queue package
// Shared sizes, codes and beat types of the timer deadline queue.
// ----------------------------------------------------------------------------
package tdq_pkg;

	localparam int CAPACITY    = 16;
	localparam int TIME_BITS   = 48;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int BUF_W       = $clog2(MAX_RESULTS);
	localparam int N_W         = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_CANCEL = 2'd1,
		OP_EXPIRE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_ADDED     = 3'd0,
		KIND_CANCELLED = 3'd1,
		KIND_NOT_FOUND = 3'd2,
		KIND_EXPIRED   = 3'd3,
		KIND_NONE_DUE  = 3'd4,
		KIND_FULL      = 3'd5
	} kind_t;

	typedef struct packed {
		logic [1:0]           operation;
		logic [31:0]          cancel_id;
		logic [TIME_BITS-1:0] deadline;
		logic [TIME_BITS-1:0] now_time;
		logic [15:0]          handler_tag;
	} cmd_t;

	typedef struct packed {
		logic [2:0]           kind;
		logic [31:0]          result_id;
		logic [15:0]          result_tag;
		logic [TIME_BITS-1:0] next_deadline;
		logic                 next_valid;
		logic                 last;
	} result_t;

	// One stored timer.
	typedef struct packed {
		logic [TIME_BITS-1:0] dl;
		logic [31:0]          id;
		logic [15:0]          tag;
	} entry_t;

endpackage
`default_nettype wire

// ===== hdl/tdq_entry_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer entry RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tdq_entry_ram (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [tdq_pkg::IDX_W-1:0] waddr,
	input  wire tdq_pkg::entry_t      wdata,
	input  wire logic [tdq_pkg::IDX_W-1:0] raddr,
	output tdq_pkg::entry_t           rdata
);
	import tdq_pkg::*;

	entry_t mem [CAPACITY];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/timer_deadline_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer deadline queue
// Pending timers ordered by deadline and id, with add, cancel and expire.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. Add stores a
// timer and returns its new id, cancel removes a timer by id, and expire
// returns every due timer in key order, up to sixteen per command.
// Results appear on result for one cycle each, marked by strobe; the
// receiver cannot stall them. The final beat of a command has last set, and
// every beat carries the earliest deadline still pending.
// Entries live in a RAM with registered read data; each search walks all
// CAPACITY slots. An add or a full add takes one walk, a cancel two (one for
// id zero), and an expire one walk per expired timer plus one.
// NOP and unknown operations are dropped without a result.
// Reset clears all slots' valid bits and sets the id counter to one; the
// RAM itself is not cleared.
// ----------------------------------------------------------------------------
module timer_deadline_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire tdq_pkg::cmd_t    cmd,
	output logic                  busy,
	output logic                  strobe,
	output tdq_pkg::result_t      result
);
	import tdq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DECIDE = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		PH_FINAL  = 2'd0,
		PH_CANCEL = 2'd1,
		PH_EXPIRE = 2'd2
	} phase_t;

	state_t               state_q;
	phase_t               phase_q;
	logic [CAPACITY-1:0]  valid_q;
	logic [31:0]          ctr_q;
	logic [31:0]          cid_q;
	logic [TIME_BITS-1:0] now_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 cmp_v_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;
	logic                 best_v_q;
	logic [IDX_W-1:0]     best_idx_q;
	entry_t               best_q;
	logic [N_W-1:0]       n_q;
	logic [N_W-1:0]       em_q;
	logic                 multi_q;
	kind_t                sr_kind_q;
	logic [31:0]          sr_id_q;
	logic [TIME_BITS-1:0] nd_q;
	logic                 nv_q;
	logic [31:0]          buf_id_q  [MAX_RESULTS];
	logic [15:0]          buf_tag_q [MAX_RESULTS];

	logic                 free_found;
	logic [IDX_W-1:0]     free_idx;
	logic                 ram_we;
	entry_t               ram_wdata;
	entry_t               ram_rdata;
	logic                 eligible;
	logic                 better;
	logic                 due;

	// First free slot.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// Entry write on an accepted add.
	assign ram_we = (state_q == ST_IDLE) && start && (op_t'(cmd.operation) == OP_ADD)
		&& free_found;
	always_comb begin
		ram_wdata.dl  = cmd.deadline;
		ram_wdata.id  = (ctr_q == 32'd0) ? 32'd1 : ctr_q;
		ram_wdata.tag = cmd.handler_tag;
	end

	tdq_entry_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx),
		.wdata (ram_wdata),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// Key compare of the slot read back against the best so far.
	assign eligible = valid_q[cmp_idx_s1] && ((phase_q != PH_CANCEL) || (ram_rdata.id == cid_q));
	assign better   = !best_v_q || (ram_rdata.dl < best_q.dl)
		|| ((ram_rdata.dl == best_q.dl) && (ram_rdata.id < best_q.id));
	assign due      = best_v_q && (best_q.dl <= now_q) && (n_q < N_W'(MAX_RESULTS));

	assign busy = (state_q != ST_IDLE);

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_FINAL;
			valid_q    <= '0;
			ctr_q      <= 32'd1;
			cnt_q      <= '0;
			cmp_v_s1   <= 1'b0;
			best_v_q   <= 1'b0;
			best_idx_q <= '0;
			best_q     <= '0;
			n_q        <= '0;
			em_q       <= '0;
			multi_q    <= 1'b0;
			sr_kind_q  <= KIND_ADDED;
			sr_id_q    <= '0;
			strobe     <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q    <= '0;
					best_v_q <= 1'b0;
					n_q      <= '0;
					em_q     <= '0;
					multi_q  <= 1'b0;
					if (start) begin
						unique case (op_t'(cmd.operation))
							OP_ADD: begin
								phase_q <= PH_FINAL;
								state_q <= ST_SCAN;
								if (free_found) begin
									valid_q[free_idx] <= 1'b1;
									ctr_q     <= (ctr_q == 32'd0) ? 32'd2 : ctr_q + 32'd1;
									sr_kind_q <= KIND_ADDED;
									sr_id_q   <= ram_wdata.id;
								end else begin
									sr_kind_q <= KIND_FULL;
									sr_id_q   <= 32'd0;
								end
							end
							OP_CANCEL: begin
								state_q   <= ST_SCAN;
								sr_kind_q <= KIND_NOT_FOUND;
								sr_id_q   <= cmd.cancel_id;
								phase_q   <= (cmd.cancel_id == 32'd0) ? PH_FINAL : PH_CANCEL;
							end
							OP_EXPIRE: begin
								state_q <= ST_SCAN;
								phase_q <= PH_EXPIRE;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (cnt_q < CNT_W'(CAPACITY)) begin
						cmp_v_s1 <= 1'b1;
						cnt_q    <= cnt_q + 1'b1;
					end else begin
						cmp_v_s1 <= 1'b0;
						if (!cmp_v_s1) begin
							state_q <= ST_DECIDE;
						end
					end
					if (cmp_v_s1 && eligible && better) begin
						best_v_q   <= 1'b1;
						best_idx_q <= cmp_idx_s1;
						best_q     <= ram_rdata;
					end
				end
				ST_DECIDE: begin
					cnt_q    <= '0;
					best_v_q <= 1'b0;
					unique case (phase_q)
						PH_CANCEL: begin
							if (best_v_q) begin
								valid_q[best_idx_q] <= 1'b0;
								sr_kind_q <= KIND_CANCELLED;
							end
							phase_q <= PH_FINAL;
							state_q <= ST_SCAN;
						end
						PH_EXPIRE: begin
							if (due) begin
								valid_q[best_idx_q] <= 1'b0;
								n_q     <= n_q + 1'b1;
								state_q <= ST_SCAN;
							end else begin
								multi_q   <= (n_q != '0);
								sr_kind_q <= KIND_NONE_DUE;
								sr_id_q   <= 32'd0;
								state_q   <= ST_EMIT;
							end
						end
						default: begin
							state_q <= ST_EMIT;
						end
					endcase
				end
				ST_EMIT: begin
					strobe <= 1'b1;
					em_q   <= em_q + 1'b1;
					if (!multi_q || (em_q == n_q - 1'b1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: command operands, scan stage, expiry buffer, result.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			cid_q <= cmd.cancel_id;
			now_q <= cmd.now_time;
		end
		cmp_idx_s1 <= cnt_q[IDX_W-1:0];
		if ((state_q == ST_DECIDE) && (phase_q == PH_EXPIRE) && due) begin
			buf_id_q[n_q[BUF_W-1:0]]  <= best_q.id;
			buf_tag_q[n_q[BUF_W-1:0]] <= best_q.tag;
		end
		if ((state_q == ST_DECIDE) && (phase_q != PH_CANCEL) && !((phase_q == PH_EXPIRE) && due))
		begin
			nv_q <= best_v_q;
			nd_q <= best_v_q ? best_q.dl : '0;
		end
		if (state_q == ST_EMIT) begin
			result.next_deadline <= nd_q;
			result.next_valid    <= nv_q;
			if (multi_q) begin
				result.kind       <= KIND_EXPIRED;
				result.result_id  <= buf_id_q[em_q[BUF_W-1:0]];
				result.result_tag <= buf_tag_q[em_q[BUF_W-1:0]];
				result.last       <= (em_q == n_q - 1'b1);
			end else begin
				result.kind       <= sr_kind_q;
				result.result_id  <= sr_id_q;
				result.result_tag <= 16'd0;
				result.last       <= 1'b1;
			end
		end
	end

	// Checks.
	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && ((result.kind == KIND_EXPIRED) || (result.kind == KIND_ADDED))
		|-> (result.result_id != 32'd0))
		else $error("added or expired timer reported with id zero");

	a_empty_deadline: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.next_valid |-> (result.next_deadline == '0))
		else $error("next deadline nonzero with no timer pending");

	a_takes_command: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.operation != OP_NOP) |=> busy)
		else $error("command accepted without going busy");

	a_strobe_seq: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("result burst broken before last beat");

endmodule
`default_nettype wire

// ===== bench/tb_timer_deadline_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline queue testbench
// Drives add, cancel and expire commands and checks every result beat
// against a behavioral model of the sorted timer table.
// ----------------------------------------------------------------------------
import tdq_pkg::*;

class tdq_scoreboard;
	logic [TIME_BITS-1:0] slot_dl [CAPACITY];
	logic [31:0]          slot_id [CAPACITY];
	logic [15:0]          slot_tag [CAPACITY];
	bit                   slot_used [CAPACITY];
	logic [31:0]          id_next;
	result_t              pending_beats [$];
	int                   errors;

	function new();
		for (int i = 0; i < CAPACITY; i++) slot_used[i] = 0;
		id_next = 32'd1;
		errors = 0;
	endfunction

	// True if slot a orders before slot b by deadline, then id.
	function bit key_lt(int a, int b);
		if (slot_dl[a] != slot_dl[b]) return slot_dl[a] < slot_dl[b];
		return slot_id[a] < slot_id[b];
	endfunction

	function int earliest();
		int best;
		best = -1;
		for (int i = 0; i < CAPACITY; i++)
			if (slot_used[i] && (best < 0 || key_lt(i, best))) best = i;
		return best;
	endfunction

	// Works out the result beats of one accepted command.
	function void note_command(cmd_t c);
		result_t beats [$];
		result_t r;
		int slot, s, n;
		logic [31:0] id;
		r = '0;
		case (op_t'(c.operation))
			OP_ADD: begin
				slot = -1;
				for (int i = 0; i < CAPACITY; i++)
					if (!slot_used[i] && slot < 0) slot = i;
				if (slot < 0) begin
					r.kind = KIND_FULL;
				end else begin
					id = id_next;
					id_next++;
					if (id == 0) begin
						id = id_next;
						id_next++;
					end
					slot_dl[slot] = c.deadline;
					slot_id[slot] = id;
					slot_tag[slot] = c.handler_tag;
					slot_used[slot] = 1;
					r.kind = KIND_ADDED;
					r.result_id = id;
				end
				beats = {beats, r};
			end
			OP_CANCEL: begin
				slot = -1;
				if (c.cancel_id != 0)
					for (int i = 0; i < CAPACITY; i++)
						if (slot_used[i] && slot_id[i] == c.cancel_id &&
						    (slot < 0 || key_lt(i, slot))) slot = i;
				r.result_id = c.cancel_id;
				if (slot < 0) begin
					r.kind = KIND_NOT_FOUND;
				end else begin
					slot_used[slot] = 0;
					r.kind = KIND_CANCELLED;
				end
				beats = {beats, r};
			end
			OP_EXPIRE: begin
				n = 0;
				while (n < MAX_RESULTS) begin
					s = earliest();
					if (s < 0 || slot_dl[s] > c.now_time) break;
					r = '0;
					r.kind = KIND_EXPIRED;
					r.result_id = slot_id[s];
					r.result_tag = slot_tag[s];
					slot_used[s] = 0;
					beats = {beats, r};
					n++;
				end
				if (n == 0) begin
					r = '0;
					r.kind = KIND_NONE_DUE;
					beats = {beats, r};
				end
			end
			default: ;
		endcase
		s = earliest();
		foreach (beats[k]) begin
			beats[k].next_deadline = (s >= 0) ? slot_dl[s] : '0;
			beats[k].next_valid = (s >= 0);
			beats[k].last = (k == beats.size() - 1);
			pending_beats = {pending_beats, beats[k]};
		end
	endfunction

	function int live_count();
		int n;
		n = 0;
		for (int i = 0; i < CAPACITY; i++) n += slot_used[i];
		return n;
	endfunction

	// Compares one result beat with the oldest expected one.
	function void check_beat(result_t got);
		result_t want;
		if (pending_beats.size() == 0) begin
			$display("%0t: unexpected beat %h", $time, got);
			errors++;
			return;
		end
		want = pending_beats.pop_front();
		if (got.kind != want.kind)
			$display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
		if (got.result_id != want.result_id)
			$display("%0t: id exp %h got %h", $time, want.result_id, got.result_id);
		if (got.result_tag != want.result_tag)
			$display("%0t: tag exp %h got %h", $time, want.result_tag, got.result_tag);
		if (got.next_deadline != want.next_deadline)
			$display("%0t: next_deadline exp %h got %h", $time,
				want.next_deadline, got.next_deadline);
		if (got.next_valid != want.next_valid)
			$display("%0t: next_valid exp %b got %b", $time, want.next_valid,
				got.next_valid);
		if (got.last != want.last)
			$display("%0t: last exp %b got %b", $time, want.last, got.last);
		if (got != want) errors++;
	endfunction
endclass

module tb_timer_deadline_queue;
	localparam int CYCLE_LIMIT = 2000000;

	logic    clk;
	logic    arst_n;
	logic    start;
	cmd_t    cmd;
	logic    busy;
	logic    strobe;
	result_t result;

	tdq_scoreboard timer_book;
	int      idle_pct;
	int      cycles;
	logic [31:0] recent_ids [$];

	timer_deadline_queue dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .strobe(strobe), .result(result)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Result beats are checked at the edge that accepts them.
	always @(posedge clk) begin
		if (arst_n && strobe) timer_book.check_beat(result);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Sends one command beat, with an optional random gap before it.
	// Start stays high after the beat is taken until the next gap or command.
	task automatic send(cmd_t c);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		timer_book.note_command(c);
		if (c.operation == OP_ADD && timer_book.pending_beats.size() > 0 &&
		    timer_book.pending_beats[$].kind == KIND_ADDED)
			recent_ids = {recent_ids, timer_book.pending_beats[$].result_id};
		if (recent_ids.size() > 32) void'(recent_ids.pop_front());
	endtask

	function automatic cmd_t make(op_t op, logic [31:0] cid, logic [47:0] dl,
		logic [47:0] now, logic [15:0] tag);
		cmd_t c;
		c.operation = op;
		c.cancel_id = cid;
		c.deadline = dl;
		c.now_time = now;
		c.handler_tag = tag;
		return c;
	endfunction

	function automatic logic [47:0] rnd48();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly small deadlines so expires hit; sometimes any value.
	task automatic random_item();
		int pick;
		logic [31:0] cid;
		pick = $urandom_range(99);
		cid = $urandom();
		if (recent_ids.size() > 0 && $urandom_range(3) != 0)
			cid = recent_ids[$urandom_range(recent_ids.size() - 1)];
		if (pick < 45)
			send(make(OP_ADD, $urandom(), ($urandom_range(3) == 0) ? rnd48() :
				48'($urandom_range(1000)), rnd48(), 16'($urandom())));
		else if (pick < 65)
			send(make(OP_CANCEL, cid, rnd48(), rnd48(), 16'($urandom())));
		else if (pick < 95)
			send(make(OP_EXPIRE, $urandom(), rnd48(), ($urandom_range(9) == 0) ?
				rnd48() : 48'($urandom_range(1200)), 16'($urandom())));
		else
			send(make(OP_NOP, $urandom(), rnd48(), rnd48(), 16'($urandom())));
	endtask

	task automatic drain();
		while (timer_book.pending_beats.size() > 0) @(posedge clk);
	endtask

	initial begin
		timer_book = new();
		cycles = 0;
		idle_pct = 0;
		arst_n = 0;
		start = 0;
		cmd = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty expire, cancel of zero, extremes, fill past full.
		send(make(OP_EXPIRE, '0, '0, '1, '0));
		send(make(OP_CANCEL, '0, '0, '0, '0));
		send(make(OP_ADD, '1, '1, '0, '1));
		send(make(OP_ADD, '0, '0, '1, '0));
		send(make(OP_CANCEL, 32'd5, '1, '1, '1));
		send(make(OP_CANCEL, 32'd2, '0, '0, '0));
		send(make(OP_NOP, '1, '1, '1, '1));
		for (int i = 0; i < 17; i++)
			send(make(OP_ADD, '0, 48'(i % 3), '0, 16'(i)));
		// Sixteen due at once, so one check empties the whole table.
		send(make(OP_EXPIRE, '0, '0, '1, '0));
		send(make(OP_EXPIRE, '0, '0, '1, '0));

		// Random phases with different sender gaps.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 74 : (ph == 3) ? 17 : 0;
			for (int k = 0; k < 46; k++) random_item();
		end

		start <= 1'b0;
		drain();
		repeat (200) @(posedge clk);
		if (timer_book.errors == 0 && timer_book.pending_beats.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
